[rtl/mbwd_pkg.sv]
// Package for the multi-word by single-word divider.
// Holds the sequencer state type, field widths and register decode constants.
// No dependencies.
`default_nettype none

package mbwd_pkg;

  // Widths of the stream fields and of the configuration bus.
  localparam int unsigned FIELD_BITS = 64;
  localparam int unsigned APB_DATA_BITS = 64;
  localparam int unsigned APB_ADDR_BITS = 4;

  // Default width of the arithmetic inside the block.
  localparam int unsigned WORD_BITS_DEF = 64;

  // Register index taken from paddr[3] (8-byte spacing).
  localparam logic REG_DIVISOR = 1'b0;

  localparam logic [FIELD_BITS-1:0] DIVISOR_RESET = FIELD_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DIVIDE
  } state_e;

endpackage : mbwd_pkg

`default_nettype wire

[rtl/multiword_by_word_divider.sv]
// Top level of the multi-word by single-word divider: APB register,
// radix-2 restoring division sequencer and output register.
// Depends on mbwd_pkg.
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  -----------------------------------------
//  s        in   s_tvalid/s_tready  tdata: dividend_word; tlast: last_word
//  m        out  m_tvalid/m_tready  tdata: quotient_word, final_remainder;
//                                   tlast: last
//  apb      in   psel/penable       divisor at byte address 0
//
// Each item yields one quotient bit per cycle through the single shared
// subtract-and-compare unit, except while a waiting result holds the last step.
// A divisor change in mid-number can leave the carried remainder not below the
// divisor; a reduction pass through the same unit then comes first.
// The input is ready only while the sequencer is idle; a waiting result holds
// back only the last step of a division. Reset is asynchronous.
`default_nettype none

module multiword_by_word_divider #(
  parameter int unsigned WORD_BITS = mbwd_pkg::WORD_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream
  input  wire logic                                s_tvalid_i,
  output logic                                     s_tready_o,
  input  wire logic [mbwd_pkg::FIELD_BITS-1:0]     s_tdata_i,   // [63:0] dividend_word
  input  wire logic                                s_tlast_i,   // last_word
  // Output stream
  output logic                                     m_tvalid_o,
  input  wire logic                                m_tready_i,
  output logic [2*mbwd_pkg::FIELD_BITS-1:0]        m_tdata_o,   // [63:0] quotient_word,
                                                                // [127:64] final_remainder
  output logic                                     m_tlast_o,   // last
  // Configuration
  input  wire logic                                psel_i,
  input  wire logic                                penable_i,
  input  wire logic                                pwrite_i,
  input  wire logic [mbwd_pkg::APB_ADDR_BITS-1:0]  paddr_i,
  input  wire logic [mbwd_pkg::APB_DATA_BITS-1:0]  pwdata_i,
  output logic [mbwd_pkg::APB_DATA_BITS-1:0]       prdata_o,
  output logic                                     pready_o
);

  import mbwd_pkg::*;

  localparam int unsigned CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  typedef struct packed {
    logic accept;
    logic step;
    logic reduce_end;
    logic divide_end;
  } ctrl_t;

  state_e                 state_q, state_d;
  ctrl_t                  ctrl;
  logic [FIELD_BITS-1:0]  divisor_q;
  logic [WORD_BITS-1:0]   rem_q;
  logic [WORD_BITS-1:0]   sh_q;
  logic [WORD_BITS-1:0]   word_q;
  logic                   last_q;
  logic [CNT_W-1:0]       cnt_q;

  logic                   out_valid_q;
  logic [WORD_BITS-1:0]   out_quot_q;
  logic [WORD_BITS-1:0]   out_rem_q;
  logic                   out_last_q;

  logic [WORD_BITS-1:0]   div_w;
  logic                   need_reduce;
  logic                   out_free;
  logic                   last_step;
  logic                   cfg_write;

  // Shared step unit.
  logic [WORD_BITS-1:0]   shifted;
  logic [WORD_BITS:0]     diff;
  logic                   take;
  logic [WORD_BITS-1:0]   rem_n;
  logic [WORD_BITS-1:0]   sh_n;

  assign div_w       = divisor_q[WORD_BITS-1:0];
  assign need_reduce = (div_w != '0) && (rem_q >= div_w);
  assign out_free    = !out_valid_q || m_tready_i;
  assign last_step   = (cnt_q == CNT_LAST);

  // The bit shifted out of the top counts as a carry above the word, which
  // forces a subtraction; the borrow then wraps back into range.
  assign shifted = {rem_q[WORD_BITS-2:0], sh_q[WORD_BITS-1]};
  assign diff    = {1'b0, shifted} - {1'b0, div_w};
  assign take    = rem_q[WORD_BITS-1] | ~diff[WORD_BITS];
  assign rem_n   = take ? diff[WORD_BITS-1:0] : shifted;
  assign sh_n    = {sh_q[WORD_BITS-2:0], take};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = need_reduce ? ST_REDUCE : ST_DIVIDE;
        end
      end
      ST_REDUCE: begin
        if (last_step) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (last_step && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl.accept = s_tvalid_i;
      end
      ST_REDUCE: begin
        ctrl.step       = 1'b1;
        ctrl.reduce_end = last_step;
      end
      ST_DIVIDE: begin
        ctrl.step       = !last_step || out_free;
        ctrl.divide_end = last_step && out_free;
      end
      default: ctrl = '0;
    endcase
  end

  assign s_tready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.accept) begin
        cnt_q <= '0;
        if (need_reduce) begin
          rem_q <= '0;
        end
      end else if (ctrl.step) begin
        cnt_q <= last_step ? '0 : cnt_q + CNT_W'(1);
        if (ctrl.divide_end && last_q) begin
          rem_q <= '0;
        end else begin
          rem_q <= rem_n;
        end
      end
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      word_q <= s_tdata_i[WORD_BITS-1:0];
      last_q <= s_tlast_i;
      sh_q   <= need_reduce ? rem_q : s_tdata_i[WORD_BITS-1:0];
    end else if (ctrl.reduce_end) begin
      sh_q <= word_q;
    end else if (ctrl.step) begin
      sh_q <= sh_n;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.divide_end) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.divide_end) begin
      out_quot_q <= sh_n;
      out_rem_q  <= last_q ? rem_n : '0;
      out_last_q <= last_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {FIELD_BITS'(out_rem_q), FIELD_BITS'(out_quot_q)};
  assign m_tlast_o  = out_last_q;

  // Configuration register.
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DIVISOR_RESET;
    end else if (cfg_write && (paddr_i[3] == REG_DIVISOR)) begin
      divisor_q <= pwdata_i;
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[3] == REG_DIVISOR) ? divisor_q : '0;

endmodule : multiword_by_word_divider

`default_nettype wire
